>>> rtl/wtbr_pkg.sv
// Shared constants, types and helpers of the wavelet tree build and rank core.
`default_nettype none
package wtbr_pkg;

    localparam int MAX_LEVELS = 4;
    localparam int MAX_TEXT   = 1024;

    localparam int NODE_COUNT = 1 << MAX_LEVELS;
    localparam int NODE_W     = MAX_LEVELS;
    localparam int AW         = MAX_LEVELS + 1;
    localparam int CNT_W      = $clog2(MAX_TEXT + 1);
    localparam int POS_W      = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int ADDR_W     = NODE_W + POS_W;
    localparam int MEM_DEPTH  = NODE_COUNT * (2 ** POS_W);
    localparam int SUB_W      = (CNT_W > AW) ? CNT_W : AW;

    localparam int FUNC_W     = 2;
    localparam int SYM_W      = 4;
    localparam int SYM_COUNT  = 16;
    localparam int REQ_W      = 11;
    localparam int ANS_W      = 11;
    localparam int ALPHA_W    = 5;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 5'd4;

    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RANK   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COUNT  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BIT   = 4'b0010,
        ST_QSTOP = 4'b0100,
        ST_QDIFF = 4'b1000
    } state_t;

    typedef struct packed {
        logic bit_we;
        logic bit_val;
        logic count_we;
    } upd_t;

    function automatic logic [AW-1:0] ceil_pow2(input logic [AW-1:0] a);
        logic [AW-1:0] u;
        u = AW'(1);
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            if (u < a)
            begin
                u = AW'(u << 1);
            end
        end
        return u;
    endfunction

endpackage
`default_nettype wire

>>> rtl/wtbr_prefix_mem.sv
// Zero-prefix store: one write port and one registered read port.
`default_nettype none
module wtbr_prefix_mem (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [wtbr_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [wtbr_pkg::CNT_W-1:0]  wr_data,
    input  wire logic [wtbr_pkg::ADDR_W-1:0] rd_addr,
    output logic      [wtbr_pkg::CNT_W-1:0]  rd_data
);
    import wtbr_pkg::*;

    logic [CNT_W-1:0] mem [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

>>> rtl/wtbr_sub_unit.sv
// Shared compare and subtract unit for code bits and rank differences.
`default_nettype none
module wtbr_sub_unit (
    input  wire logic [wtbr_pkg::SUB_W-1:0] x,
    input  wire logic [wtbr_pkg::SUB_W-1:0] y,
    output logic                            ge,
    output logic      [wtbr_pkg::SUB_W-1:0] diff
);
    import wtbr_pkg::*;

    assign ge   = (x >= y);
    assign diff = x - y;

endmodule
`default_nettype wire

>>> rtl/wtbr_state_regs.sv
// Node lengths, node zero totals, symbol counters and text length.
`default_nettype none
module wtbr_state_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [wtbr_pkg::NODE_W-1:0] sel_node,
    input  wire logic [wtbr_pkg::SYM_W-1:0]  sel_sym,
    input  wire wtbr_pkg::upd_t              upd,
    output logic      [wtbr_pkg::CNT_W-1:0]  len_rd,
    output logic      [wtbr_pkg::CNT_W-1:0]  zero_wr,
    output logic      [wtbr_pkg::CNT_W-1:0]  total_rd,
    output logic      [wtbr_pkg::CNT_W-1:0]  text_len
);
    import wtbr_pkg::*;

    logic [CNT_W-1:0] node_len_reg   [NODE_COUNT];
    logic [CNT_W-1:0] zero_total_reg [NODE_COUNT];
    logic [CNT_W-1:0] sym_total_reg  [SYM_COUNT];
    logic [CNT_W-1:0] text_len_reg;

    assign len_rd   = node_len_reg[sel_node];
    assign zero_wr  = zero_total_reg[sel_node] + CNT_W'(!upd.bit_val);
    assign total_rd = sym_total_reg[sel_sym];
    assign text_len = text_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                node_len_reg[i]   <= '0;
                zero_total_reg[i] <= '0;
            end
            for (int i = 0; i < SYM_COUNT; i++)
            begin
                sym_total_reg[i] <= '0;
            end
            text_len_reg <= '0;
        end
        else
        begin
            if (upd.bit_we)
            begin
                node_len_reg[sel_node]   <= node_len_reg[sel_node] + CNT_W'(1);
                zero_total_reg[sel_node] <= zero_wr;
            end
            if (upd.count_we)
            begin
                sym_total_reg[sel_sym] <= sym_total_reg[sel_sym] + CNT_W'(1);
                text_len_reg           <= text_len_reg + CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/wavelet_tree_build_rank_core.sv
// Wavelet tree build and rank core: sequencer, operand registers and result port.
// Append: busy in ST_BIT while storing the code bits (1 to MAX_LEVELS); done is registered at the end.
// Rank: busy in ST_QSTOP then ST_QDIFF, as both prefix reads share the single prefix read port.
// Count, refused requests and unknown func: result in the cycle after accept, never busy.
// The receiver cannot stall; done pulses one cycle per result, a new beat may start in that cycle.
// Reset clears counters, node lengths and sequencer; the prefix store is not cleared.
`default_nettype none
module wavelet_tree_build_rank_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [wtbr_pkg::FUNC_W-1:0]  func,
    input  wire logic [wtbr_pkg::SYM_W-1:0]   symbol,
    input  wire logic [wtbr_pkg::SYM_W-1:0]   node,
    input  wire logic [wtbr_pkg::REQ_W-1:0]   start_req,
    input  wire logic [wtbr_pkg::REQ_W-1:0]   stop,
    output logic                              done,
    output logic      [wtbr_pkg::ANS_W-1:0]   answer,
    output logic                              error,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [wtbr_pkg::ALPHA_W-1:0] cfg_data
);
    import wtbr_pkg::*;

    state_t             state_reg, state_next;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      half_reg, half_next;
    logic [NODE_W-1:0]  cur_reg, cur_next;
    logic [SYM_W-1:0]   sym_reg;
    logic [NODE_W-1:0]  qnode_reg;
    logic [REQ_W-1:0]   start_reg;
    logic [REQ_W-1:0]   stop_reg;
    logic [CNT_W-1:0]   stop_val_reg, stop_val_next;
    logic [ANS_W-1:0]   answer_reg, answer_next;
    logic               error_reg, error_next;
    logic               done_reg, done_next;

    logic               accept;
    logic [NODE_W-1:0]  node_idx;
    logic               node_ok;
    logic [AW-1:0]      a_eff;
    logic [AW-1:0]      upper;
    logic [AW-1:0]      red;
    logic               short_code;
    logic [AW-1:0]      prep_idx;
    logic [AW-1:0]      prep_half;
    logic               app_err;
    logic [CNT_W-1:0]   nlen;
    logic               rank_err;
    logic               last_bit;

    logic [NODE_W-1:0]  sel_node;
    logic [SYM_W-1:0]   sel_sym;
    upd_t               upd;
    logic [CNT_W-1:0]   len_rd;
    logic [CNT_W-1:0]   zero_wr;
    logic [CNT_W-1:0]   total_rd;
    logic [CNT_W-1:0]   text_len;

    logic               mem_we;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [CNT_W-1:0]   rd_data;

    logic [SUB_W-1:0]   sub_x;
    logic [SUB_W-1:0]   sub_y;
    logic               sub_ge;
    logic [SUB_W-1:0]   sub_diff;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign answer    = answer_reg;
    assign error     = error_reg;
    assign cfg_ready = 1'b1;

    assign node_idx = NODE_W'(node);
    assign node_ok  = (32'(node) < NODE_COUNT);

    // clamp the alphabet to the tree's range
    always_comb
    begin
        if (alpha_reg < ALPHA_W'(2))
        begin
            a_eff = AW'(2);
        end
        else if (32'(alpha_reg) > NODE_COUNT)
        begin
            a_eff = AW'(NODE_COUNT);
        end
        else
        begin
            a_eff = AW'(alpha_reg);
        end
    end

    assign upper      = ceil_pow2(a_eff);
    assign red        = upper - a_eff;
    assign short_code = ((32'(symbol) + 2 * 32'(red)) >= 32'(upper));
    assign prep_idx   = short_code ? (AW'(symbol) - ((a_eff - red) >> 1)) : AW'(symbol);
    assign prep_half  = short_code ? (upper >> 2) : (upper >> 1);
    assign app_err    = (32'(text_len) >= MAX_TEXT) || (32'(symbol) >= 32'(a_eff));

    assign nlen     = node_ok ? len_rd : '0;
    assign rank_err = (start_req > stop) || (32'(stop) > 32'(nlen));
    assign last_bit = (half_reg[AW-1:1] == '0);

    assign sel_node = (state_reg == ST_BIT) ? cur_reg : node_idx;
    assign sel_sym  = (state_reg == ST_BIT) ? sym_reg : symbol;

    assign wr_addr = {cur_reg, POS_W'(len_rd)};
    assign rd_addr = (state_reg == ST_QSTOP) ? {qnode_reg, POS_W'(start_reg - REQ_W'(1))}
                                             : {node_idx, POS_W'(stop - REQ_W'(1))};

    always_comb
    begin
        if (state_reg == ST_QDIFF)
        begin
            sub_x = SUB_W'(stop_val_reg);
            sub_y = (start_reg == '0) ? '0 : SUB_W'(rd_data);
        end
        else
        begin
            sub_x = SUB_W'(idx_reg);
            sub_y = SUB_W'(half_reg);
        end
    end

    wtbr_sub_unit u_sub (
        .x    (sub_x),
        .y    (sub_y),
        .ge   (sub_ge),
        .diff (sub_diff)
    );

    wtbr_state_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .sel_node (sel_node),
        .sel_sym  (sel_sym),
        .upd      (upd),
        .len_rd   (len_rd),
        .zero_wr  (zero_wr),
        .total_rd (total_rd),
        .text_len (text_len)
    );

    wtbr_prefix_mem u_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (wr_addr),
        .wr_data (zero_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        half_next     = half_reg;
        cur_next      = cur_reg;
        stop_val_next = stop_val_reg;
        answer_next   = answer_reg;
        error_next    = error_reg;
        done_next     = 1'b0;
        upd           = '0;
        mem_we        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    answer_next = '0;
                    error_next  = 1'b0;
                    case (func)
                        FUNC_APPEND:
                        begin
                            if (app_err)
                            begin
                                error_next = 1'b1;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                idx_next   = prep_idx;
                                half_next  = prep_half;
                                cur_next   = NODE_W'(1);
                                state_next = ST_BIT;
                            end
                        end
                        FUNC_RANK:
                        begin
                            if (rank_err)
                            begin
                                error_next = 1'b1;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_QSTOP;
                            end
                        end
                        FUNC_COUNT:
                        begin
                            answer_next = ANS_W'(total_rd);
                            done_next   = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_BIT:
            begin
                // store one code bit and descend
                upd.bit_we  = 1'b1;
                upd.bit_val = sub_ge;
                mem_we      = 1'b1;
                idx_next    = sub_ge ? AW'(sub_diff) : idx_reg;
                half_next   = half_reg >> 1;
                cur_next    = NODE_W'({cur_reg, sub_ge});
                if (last_bit)
                begin
                    upd.count_we = 1'b1;
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_QSTOP:
            begin
                stop_val_next = (stop_reg == '0) ? '0 : rd_data;
                state_next    = ST_QDIFF;
            end
            ST_QDIFF:
            begin
                answer_next = ANS_W'(sub_diff);
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            alpha_reg <= ALPHA_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                alpha_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        half_reg     <= half_next;
        cur_reg      <= cur_next;
        stop_val_reg <= stop_val_next;
        answer_reg   <= answer_next;
        error_reg    <= error_next;
        if (accept)
        begin
            sym_reg   <= symbol;
            qnode_reg <= node_idx;
            start_reg <= start_req;
            stop_reg  <= stop;
        end
    end

endmodule
`default_nettype wire

>>> rtl/wtbr_checker.sv
// Port-level checker for the wavelet tree core, bound to the top level.
`default_nettype none
module wtbr_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       busy,
    input  wire logic                       done,
    input  wire logic [wtbr_pkg::ANS_W-1:0] answer,
    input  wire logic                       error
);
    import wtbr_pkg::*;

    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted beat neither started work nor gave a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("work ended without a result");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !(start && !busy)) |=> !done)
        else $error("result without an accepted beat");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error) |-> (answer == '0))
        else $error("refused beat carries a non-zero answer");

endmodule

bind wavelet_tree_build_rank_core wtbr_checker u_wtbr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .answer (answer),
    .error  (error)
);
`default_nettype wire
